>>> rtl/core/dhlt_pkg.sv
// Shared constants, register indexes and fixed-point helpers for the DH link transform.
package dhlt_pkg;

    localparam int CORDIC_STAGES_DEF = 30;

    localparam int WORD_W  = 32;
    localparam int CIDX_W  = 3;
    localparam int ACC_W   = 34;
    localparam int PROD_W  = 64;

    localparam logic [CIDX_W-1:0] REG_JOINT_IS_REVOLUTE = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SIN_TWIST         = 3'd1;
    localparam logic [CIDX_W-1:0] REG_COS_TWIST         = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SIN_ANGLE_SETUP   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_COS_ANGLE_SETUP   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_LINK_LENGTH       = 3'd5;
    localparam logic [CIDX_W-1:0] REG_OFFSET_SETUP      = 3'd6;

    localparam logic signed [WORD_W-1:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [ACC_W-1:0]  PI_Q28      = 34'sd843314857;
    localparam logic signed [ACC_W-1:0]  TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [ACC_W-1:0]  HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [ACC_W-1:0]  CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ACC_W-1:0]  SAT_HI_Q30  = 34'sd1073741824;
    localparam logic signed [ACC_W-1:0]  SAT_LO_Q30  = -34'sd1073741824;
    localparam logic signed [ACC_W-1:0]  SAT_HI_I32  = 34'sd2147483647;
    localparam logic signed [ACC_W-1:0]  SAT_LO_I32  = -34'sd2147483648;
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = 64'sd536870912;

    function automatic logic signed [ACC_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000008;
            5'd28: v = 34'sh000000004;
            5'd29: v = 34'sh000000002;
            5'd30: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_q30(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v > SAT_HI_Q30) ? SAT_HI_Q30 : ((v < SAT_LO_Q30) ? SAT_LO_Q30 : v);
        return t[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_i32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v > SAT_HI_I32) ? SAT_HI_I32 : ((v < SAT_LO_I32) ? SAT_LO_I32 : v);
        return t[WORD_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + ROUND_HALF;
        return signed'(t[PROD_W-1:PROD_W-ACC_W]);
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_reg(input logic signed [WORD_W-1:0] r);
        return sat_q30(ACC_W'(r));
    endfunction

endpackage

>>> rtl/core/dh_link_transform.sv
// Pipelined Denavit-Hartenberg link transform: top three matrix rows per joint word.
//
// A joint word enters on joint_valid/joint_ready and one result word leaves on
// result_valid/result_ready with the eleven matrix entries as separate ports.
// Link set-up is written on the cfg channel (cfg_index, cfg_data); cfg_ready is
// always high. Writes must be made only while no word is in flight; the block
// itself does not enforce this. result_valid rises once the word has passed
// CORDIC_STAGES + 5 registers: angle wrap, quadrant fold, one CORDIC iteration
// per stage, trig select, the six 32x32 multiplies, then round and saturate into
// the output register. One word is accepted each cycle unless the output stall
// below holds the pipeline; the CORDIC stage count sets the latency.
// When the receiver holds result_ready low with a result waiting, every stage
// holds and joint_ready drops; no word is lost or repeated.
// Reset empties the pipeline and loads the link set-up with a revolute joint,
// zero twist, zero set-up angle, zero length and zero offset.
module dh_link_transform #(
    parameter int CORDIC_STAGES = dhlt_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dhlt_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [dhlt_pkg::WORD_W-1:0]           cfg_data,
    input  logic                                  joint_valid,
    output logic                                  joint_ready,
    input  logic signed [dhlt_pkg::WORD_W-1:0]    joint_value,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r00,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r01,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r02,
    output logic signed [dhlt_pkg::WORD_W-1:0]    pos_x,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r10,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r11,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r12,
    output logic signed [dhlt_pkg::WORD_W-1:0]    pos_y,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r21,
    output logic signed [dhlt_pkg::WORD_W-1:0]    r22,
    output logic signed [dhlt_pkg::WORD_W-1:0]    pos_z
);
    import dhlt_pkg::*;

    logic                       revolute_reg;
    logic signed [WORD_W-1:0]   sin_twist_reg;
    logic signed [WORD_W-1:0]   cos_twist_reg;
    logic signed [WORD_W-1:0]   sin_setup_reg;
    logic signed [WORD_W-1:0]   cos_setup_reg;
    logic signed [WORD_W-1:0]   length_reg;
    logic signed [WORD_W-1:0]   offset_reg;

    logic                       adv;

    logic                       w_valid_reg;
    logic signed [ACC_W-1:0]    w_ang_reg;
    logic signed [WORD_W-1:0]   w_jv_reg;
    logic signed [ACC_W-1:0]    w_ang_next;
    logic signed [ACC_W-1:0]    jv_ext;

    logic                       cv_reg  [0:CORDIC_STAGES];
    logic signed [ACC_W-1:0]    cx_reg  [0:CORDIC_STAGES];
    logic signed [ACC_W-1:0]    cy_reg  [0:CORDIC_STAGES];
    logic signed [ACC_W-1:0]    cz_reg  [0:CORDIC_STAGES];
    logic                       cneg_reg[0:CORDIC_STAGES];
    logic signed [WORD_W-1:0]   cjv_reg [0:CORDIC_STAGES];
    logic signed [ACC_W-1:0]    f_ang_next;
    logic                       f_neg_next;

    logic                       s_valid_reg;
    logic signed [WORD_W-1:0]   s_sin_reg, s_cos_reg, s_d_reg;
    logic signed [WORD_W-1:0]   s_sa_reg, s_ca_reg, s_nsa_reg, s_nca_reg;
    logic signed [WORD_W-1:0]   s_sin_next, s_cos_next, s_d_next;
    logic signed [WORD_W-1:0]   sx_sat, sy_sat, sa_sat, ca_sat;

    logic                       m_valid_reg;
    logic signed [PROD_W-1:0]   m_ncas_reg, m_sas_reg, m_ac_reg;
    logic signed [PROD_W-1:0]   m_cac_reg, m_nsac_reg, m_as_reg;
    logic signed [WORD_W-1:0]   m_sin_reg, m_cos_reg, m_sa_reg, m_ca_reg, m_d_reg;

    logic                       res_valid_reg;
    logic signed [WORD_W-1:0]   r00_reg, r01_reg, r02_reg, px_reg;
    logic signed [WORD_W-1:0]   r10_reg, r11_reg, r12_reg, py_reg;
    logic signed [WORD_W-1:0]   r21_reg, r22_reg, pz_reg;

    assign cfg_ready   = 1'b1;
    assign adv         = !res_valid_reg || result_ready;
    assign joint_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revolute_reg  <= 1'b1;
            sin_twist_reg <= '0;
            cos_twist_reg <= ONE_Q30;
            sin_setup_reg <= '0;
            cos_setup_reg <= ONE_Q30;
            length_reg    <= '0;
            offset_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_JOINT_IS_REVOLUTE: revolute_reg  <= cfg_data[0];
                REG_SIN_TWIST:         sin_twist_reg <= signed'(cfg_data);
                REG_COS_TWIST:         cos_twist_reg <= signed'(cfg_data);
                REG_SIN_ANGLE_SETUP:   sin_setup_reg <= signed'(cfg_data);
                REG_COS_ANGLE_SETUP:   cos_setup_reg <= signed'(cfg_data);
                REG_LINK_LENGTH:       length_reg    <= signed'(cfg_data);
                REG_OFFSET_SETUP:      offset_reg    <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // wrap into [-pi, pi)
    always_comb
    begin
        jv_ext = ACC_W'(joint_value);
        if (jv_ext >= PI_Q28)
            w_ang_next = jv_ext - TWO_PI_Q28;
        else if (jv_ext < -PI_Q28)
            w_ang_next = jv_ext + TWO_PI_Q28;
        else
            w_ang_next = jv_ext;
    end

    // fold into [-pi/2, pi/2]
    always_comb
    begin
        f_neg_next = 1'b1;
        if (w_ang_reg > HALF_PI_Q28)
            f_ang_next = w_ang_reg - PI_Q28;
        else if (w_ang_reg < -HALF_PI_Q28)
            f_ang_next = w_ang_reg + PI_Q28;
        else
        begin
            f_ang_next = w_ang_reg;
            f_neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            cv_reg[0]   <= 1'b0;
        end
        else if (adv)
        begin
            w_valid_reg <= joint_valid;
            cv_reg[0]   <= w_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_ang_reg   <= w_ang_next;
            w_jv_reg    <= joint_value;
            cx_reg[0]   <= CORDIC_GAIN;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= f_ang_next <<< 2;
            cneg_reg[0] <= f_neg_next;
            cjv_reg[0]  <= w_jv_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (adv)
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cz_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + atan_q30(5'(i));
                end
                cneg_reg[i+1] <= cneg_reg[i];
                cjv_reg[i+1]  <= cjv_reg[i];
            end
        end
    end

    // select theta and d sources
    always_comb
    begin
        sx_sat = sat_q30(cx_reg[CORDIC_STAGES]);
        sy_sat = sat_q30(cy_reg[CORDIC_STAGES]);
        sa_sat = sat_reg(sin_twist_reg);
        ca_sat = sat_reg(cos_twist_reg);
        if (revolute_reg)
        begin
            s_cos_next = cneg_reg[CORDIC_STAGES] ? -sx_sat : sx_sat;
            s_sin_next = cneg_reg[CORDIC_STAGES] ? -sy_sat : sy_sat;
            s_d_next   = offset_reg;
        end
        else
        begin
            s_cos_next = sat_reg(cos_setup_reg);
            s_sin_next = sat_reg(sin_setup_reg);
            s_d_next   = cjv_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s_valid_reg   <= cv_reg[CORDIC_STAGES];
            m_valid_reg   <= s_valid_reg;
            res_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_sin_reg  <= s_sin_next;
            s_cos_reg  <= s_cos_next;
            s_d_reg    <= s_d_next;
            s_sa_reg   <= sa_sat;
            s_ca_reg   <= ca_sat;
            s_nsa_reg  <= -sa_sat;
            s_nca_reg  <= -ca_sat;

            m_ncas_reg <= PROD_W'(s_nca_reg) * PROD_W'(s_sin_reg);
            m_sas_reg  <= PROD_W'(s_sa_reg) * PROD_W'(s_sin_reg);
            m_ac_reg   <= PROD_W'(length_reg) * PROD_W'(s_cos_reg);
            m_cac_reg  <= PROD_W'(s_ca_reg) * PROD_W'(s_cos_reg);
            m_nsac_reg <= PROD_W'(s_nsa_reg) * PROD_W'(s_cos_reg);
            m_as_reg   <= PROD_W'(length_reg) * PROD_W'(s_sin_reg);
            m_sin_reg  <= s_sin_reg;
            m_cos_reg  <= s_cos_reg;
            m_sa_reg   <= s_sa_reg;
            m_ca_reg   <= s_ca_reg;
            m_d_reg    <= s_d_reg;

            r00_reg    <= m_cos_reg;
            r01_reg    <= sat_q30(round_q30(m_ncas_reg));
            r02_reg    <= sat_q30(round_q30(m_sas_reg));
            px_reg     <= sat_i32(round_q30(m_ac_reg));
            r10_reg    <= m_sin_reg;
            r11_reg    <= sat_q30(round_q30(m_cac_reg));
            r12_reg    <= sat_q30(round_q30(m_nsac_reg));
            py_reg     <= sat_i32(round_q30(m_as_reg));
            r21_reg    <= m_sa_reg;
            r22_reg    <= m_ca_reg;
            pz_reg     <= m_d_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign r00   = r00_reg;
    assign r01   = r01_reg;
    assign r02   = r02_reg;
    assign pos_x = px_reg;
    assign r10   = r10_reg;
    assign r11   = r11_reg;
    assign r12   = r12_reg;
    assign pos_y = py_reg;
    assign r21   = r21_reg;
    assign r22   = r22_reg;
    assign pos_z = pz_reg;

endmodule
